>>> hdl/assert_macros.svh
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SSH_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define SSH_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/ssh_pkg.sv
// Types and round constants shared by the hasher controller and datapath.
package ssh_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } ssh_state_type;

   typedef enum logic [1:0] {
      PH_MARK,
      PH_ZERO,
      PH_LEN
   } ssh_phase_type;

   typedef enum logic [1:0] {
      SEL_INPUT,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } ssh_sel_type;

   typedef struct packed {
      logic        push;
      ssh_sel_type sel;
      logic        count_len;
      logic        round_en;
      logic [5:0]  round_idx;
      logic        update;
      logic        reinit;
      logic [2:0]  word_idx;
   } ssh_cmd_type;

   typedef struct packed {
      logic blk_last;
      logic at_len;
   } ssh_status_type;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

>>> hdl/ssh_ctrl.sv
// Hasher controller: request intake, padding sequence, round count, digest output.
`include "assert_macros.svh"

module ssh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_byte_valid,
   input  logic                    req_end_of_message,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word,
   output ssh_pkg::ssh_cmd_type    cmd,
   input  ssh_pkg::ssh_status_type status
);
   import ssh_pkg::*;

   ssh_state_type state_ff, state_in;
   ssh_phase_type phase_ff, phase_in;
   logic          pad_ff, pad_in;
   logic          fin_ff, fin_in;
   logic [5:0]    round_ff, round_in;
   logic [2:0]    word_ff, word_in;

   // Hold control state across cycles.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MARK;
         pad_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pad_ff   <= pad_in;
         fin_ff   <= fin_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   // Next state and sequence counters.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      pad_in   = pad_ff;
      fin_in   = fin_ff;
      round_in = round_ff;
      word_in  = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_end_of_message) begin
                  pad_in   = 1'b1;
                  phase_in = PH_MARK;
               end
               if (req_byte_valid && status.blk_last) begin
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (phase_ff == PH_MARK) begin
               phase_in = PH_ZERO;
            end else if (phase_ff == PH_ZERO && status.at_len) begin
               phase_in = PH_LEN;
            end
            if (status.blk_last) begin
               state_in = ST_ROUND;
               fin_in   = (phase_ff == PH_LEN);
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fin_ff) begin
               state_in = ST_EMIT;
               fin_in   = 1'b0;
               pad_in   = 1'b0;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive handshakes and datapath commands.
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_EMIT);
      rsp_word_index = word_ff;
      rsp_last_word  = (word_ff == 3'd7);
      cmd            = '0;
      cmd.sel        = SEL_INPUT;
      cmd.round_idx  = round_ff;
      cmd.word_idx   = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_byte_valid) begin
               cmd.push      = 1'b1;
               cmd.count_len = 1'b1;
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            if (phase_ff == PH_MARK) begin
               cmd.sel = SEL_MARK;
            end else if (phase_ff == PH_ZERO && !status.at_len) begin
               cmd.sel = SEL_ZERO;
            end else begin
               cmd.sel = SEL_LEN;
            end
         end
         ST_ROUND:  cmd.round_en = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_EMIT:   cmd.reinit = !rsp_stall && (word_ff == 3'd7);
         default: ;
      endcase
   end

   `SSH_ASSERT_SAME(a_no_intake_on_emit, clock, reset, rsp_valid, req_stall,
      "request taken while digest is emitted")
   `SSH_ASSERT_NEXT(a_rounds_end, clock, reset,
      state_ff == ST_ROUND && round_ff == 6'd63, state_ff == ST_UPDATE,
      "round count did not end in chain update")
   `SSH_ASSERT_NEXT(a_emit_clears, clock, reset,
      state_ff == ST_EMIT && !rsp_stall && word_ff == 3'd7,
      state_ff == ST_IDLE && !pad_ff && !fin_ff,
      "message state not cleared after digest")

endmodule

>>> hdl/ssh_datapath.sv
// Hasher datapath: block shift line, message schedule, round logic, chaining state.
`include "assert_macros.svh"

module ssh_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_data_byte,
   input  ssh_pkg::ssh_cmd_type    cmd,
   output ssh_pkg::ssh_status_type status,
   output logic [31:0]             rsp_digest_word
);
   import ssh_pkg::*;

   logic [511:0] blk_ff, blk_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  len_ff, len_in;
   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic [31:0]  vars_ff [8];
   logic [31:0]  vars_in [8];
   logic [63:0]  len_bits;
   logic [7:0]   push_byte;
   logic [31:0]  w_cur;
   logic [31:0]  w_new;
   logic [31:0]  t1;
   logic [31:0]  t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
      rotr = (x >> s) | (x << (32 - s));
   endfunction

   // Select the byte to push: request data, padding mark, zero or length.
   assign len_bits = {len_ff, 3'b000};
   always_comb begin
      case (cmd.sel)
         SEL_INPUT: push_byte = req_data_byte;
         SEL_MARK:  push_byte = PAD_MARK;
         SEL_ZERO:  push_byte = 8'h00;
         SEL_LEN:   push_byte = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
         default:   push_byte = 8'h00;
      endcase
   end

   // Schedule word for this round and the one sixteen rounds ahead.
   always_comb begin
      logic [31:0] w1;
      logic [31:0] w9;
      logic [31:0] w14;
      w_cur = blk_ff[511:480];
      w1    = blk_ff[479:448];
      w9    = blk_ff[223:192];
      w14   = blk_ff[63:32];
      w_new = w_cur + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w9
              + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));
   end

   // One compression round.
   always_comb begin
      t1 = vars_ff[7] + (rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25))
           + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
           + ROUND_K[cmd.round_idx] + w_cur;
      t2 = (rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22))
           + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
              ^ (vars_ff[1] & vars_ff[2]));
   end

   // Next values of block line, fill, length, working and chaining words.
   always_comb begin
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      vars_in  = vars_ff;
      chain_in = chain_ff;
      if (cmd.push) begin
         blk_in  = {blk_ff[503:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (status.blk_last) begin
            vars_in = chain_ff;
         end
      end
      if (cmd.count_len) begin
         len_in = len_ff + 61'd1;
      end
      if (cmd.round_en) begin
         blk_in     = {blk_ff[479:0], w_new};
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
      if (cmd.update) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
      if (cmd.reinit) begin
         chain_in = HASH_INIT;
         len_in   = '0;
      end
   end

   // Hold message state; reset restores the initial hash.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         len_ff   <= '0;
         chain_ff <= HASH_INIT;
      end else begin
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         chain_ff <= chain_in;
      end
   end

   // Hold block line and working words.
   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      vars_ff <= vars_in;
   end

   assign status.blk_last = (fill_ff == 6'd63);
   assign status.at_len   = (fill_ff == 6'd56);
   assign rsp_digest_word = chain_ff[cmd.word_idx];

   `SSH_ASSERT_SAME(a_reinit_block_empty, clock, reset, cmd.reinit, fill_ff == 6'd0,
      "digest emitted with a partial block pending")
   `SSH_ASSERT_SAME(a_push_not_in_rounds, clock, reset, cmd.push, !cmd.round_en,
      "byte pushed during compression rounds")

endmodule

>>> hdl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher top level: controller and datapath.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   data_byte, byte_valid, end_of_message
//   rsp_      out         rsp_valid / rsp_stall   digest_word, word_index, last_word
//
// A request that does not complete a block is taken without a stall.
// A full block runs 64 compression rounds, then a chain update.
// End of message pushes padding one byte per cycle up to the block end,
// then compresses (one or two blocks), then offers eight digest words.
// req_stall is high whenever the block is not idle; rsp_stall holds the word.
// Reset is synchronous.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import ssh_pkg::*;

   ssh_cmd_type    cmd;
   ssh_status_type status;

   ssh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .cmd                (cmd),
      .status             (status)
   );

   ssh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule
